FILE: rtl/idd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idd_pkg;

    // Default operand width of the datapath
    localparam int DATA_WIDTH_DEF = 64;

    // Configuration register indexes
    localparam logic CFG_DIVISOR    = 1'b0;
    localparam logic CFG_RECIPROCAL = 1'b1;

    // Register values after reset
    localparam int DIVISOR_RESET    = 1;
    localparam int RECIPROCAL_RESET = 0;

endpackage

`default_nettype wire

FILE: rtl/idd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-stage pipelined DATA_WIDTH x DATA_WIDTH multiplier with sideband.
// Stage 1: four half-width partial products.
// Stage 2: middle column sum.
// Stage 3: final sum; product split into high and low halves.
module idd_mul
    import idd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int SIDE_W     = DATA_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire logic [DATA_WIDTH-1:0]   in_a,
    input  wire logic [DATA_WIDTH-1:0]   in_b,
    input  wire logic [SIDE_W-1:0]       in_side,
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic [DATA_WIDTH-1:0]   out_hi,
    output      logic [DATA_WIDTH-1:0]   out_lo,
    output      logic [SIDE_W-1:0]       out_side
);

    localparam int LW   = (DATA_WIDTH + 1) / 2;
    localparam int HW   = DATA_WIDTH - LW;
    localparam int SUMW = 2 * DATA_WIDTH - LW;
    localparam int P00W = 2 * LW;
    localparam int PXW  = LW + HW;
    localparam int P11W = 2 * HW;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  rdy1, rdy2, rdy3;

    logic [2*LW-1:0]       p00_reg;
    logic [LW+HW-1:0]      p01_reg;
    logic [LW+HW-1:0]      p10_reg;
    logic [2*HW-1:0]       p11_reg;
    logic [SIDE_W-1:0]     side1_reg;

    logic [SUMW-1:0]       mid_reg;
    logic [SUMW-1:0]       mid_next;
    logic [LW-1:0]         p00lo2_reg;
    logic [2*HW-1:0]       p11_2_reg;
    logic [SIDE_W-1:0]     side2_reg;

    logic [SUMW-1:0]       sum_next;
    logic [DATA_WIDTH-1:0] hi_reg;
    logic [DATA_WIDTH-1:0] lo_reg;
    logic [SIDE_W-1:0]     side3_reg;

    // Backpressure: a stage moves when empty or when the next one moves
    assign rdy3     = ~v3_reg | out_ready;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: partial products
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            p00_reg   <= P00W'(in_a[LW-1:0]) * P00W'(in_b[LW-1:0]);
            p01_reg   <= PXW'(in_a[LW-1:0]) * PXW'(in_b[DATA_WIDTH-1:LW]);
            p10_reg   <= PXW'(in_a[DATA_WIDTH-1:LW]) * PXW'(in_b[LW-1:0]);
            p11_reg   <= P11W'(in_a[DATA_WIDTH-1:LW]) * P11W'(in_b[DATA_WIDTH-1:LW]);
            side1_reg <= in_side;
        end
    end

    // Stage 2: middle column, carries from the lowest product
    assign mid_next = SUMW'(p01_reg) + SUMW'(p10_reg) + SUMW'(p00_reg[2*LW-1:LW]);

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            mid_reg    <= mid_next;
            p00lo2_reg <= p00_reg[LW-1:0];
            p11_2_reg  <= p11_reg;
            side2_reg  <= side1_reg;
        end
    end

    // Stage 3: product bits from LW upward
    assign sum_next = mid_reg + (SUMW'(p11_2_reg) << LW);

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            hi_reg    <= sum_next[SUMW-1:HW];
            lo_reg    <= {sum_next[HW-1:0], p00lo2_reg};
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_hi    = hi_reg;
    assign out_lo    = lo_reg;
    assign out_side  = side3_reg;

endmodule

`default_nettype wire

FILE: rtl/idd_fix.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-stage correction: decide the single decrement, then form
// quotient and remainder; divisor one bypasses to dividend / zero.
module idd_fix
    import idd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [DATA_WIDTH-1:0] in_prod_hi,
    input  wire logic [DATA_WIDTH-1:0] in_prod_lo,
    input  wire logic [DATA_WIDTH-1:0] in_est,
    input  wire logic [DATA_WIDTH-1:0] in_dividend,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [DATA_WIDTH-1:0] out_quotient,
    output      logic [DATA_WIDTH-1:0] out_remainder
);

    logic                  v1_reg, v2_reg;
    logic                  rdy1, rdy2;

    logic                  dec_reg;
    logic                  dec_next;
    logic [DATA_WIDTH-1:0] diff_reg;
    logic [DATA_WIDTH-1:0] est_reg;
    logic [DATA_WIDTH-1:0] x_reg;

    logic                  bypass;
    logic [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;

    assign rdy2     = ~v2_reg | out_ready;
    assign rdy1     = ~v1_reg | rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    // Stage 1: estimate too large if product overflows or exceeds dividend
    assign dec_next = (in_prod_hi != '0) || (in_prod_lo > in_dividend);

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            dec_reg  <= dec_next;
            diff_reg <= in_dividend - in_prod_lo;
            est_reg  <= in_est;
            x_reg    <= in_dividend;
        end
    end

    // Stage 2: apply any decrement (remainder grows by one divisor); divisor one bypasses
    assign bypass = (divisor == DATA_WIDTH'(DIVISOR_RESET));

    always_comb begin
        if (bypass) begin
            quot_next = x_reg;
            rem_next  = '0;
        end else if (dec_reg) begin
            quot_next = est_reg - DATA_WIDTH'(1);
            rem_next  = diff_reg + divisor;
        end else begin
            quot_next = est_reg;
            rem_next  = diff_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign out_valid     = v2_reg;
    assign out_quotient  = quot_reg;
    assign out_remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/invariant_divisor_divmod_core.sv
// Throughput: one dividend per cycle; two 3-stage multipliers and a
// 2-stage correction, each stage held only by backpressure from its successor.
// Reset (aresetn low, synchronous) empties the pipeline, divisor becomes 1
// and reciprocal 0.
`timescale 1ns / 1ps
`default_nettype none

module invariant_divisor_divmod_core
    import idd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration write port
    input  wire logic                                    cfg_we,
    input  wire logic                                    cfg_addr,
    input  wire logic [DATA_WIDTH-1:0]                   cfg_wdata,
    // request: dividend
    input  wire logic                                    s_tvalid,
    output      logic                                    s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]         s_tdata,  // dividend
    // result: quotient, remainder
    output      logic                                    m_tvalid,
    input  wire logic                                    m_tready,
    output      logic [((2*DATA_WIDTH+7)/8)*8-1:0]       m_tdata   // quotient, remainder
);

    localparam int OUT_TW = ((2 * DATA_WIDTH + 7) / 8) * 8;

    logic [DATA_WIDTH-1:0]   divisor_reg;
    logic [DATA_WIDTH-1:0]   recip_reg;

    logic                    m1_valid, m1_ready;
    logic [DATA_WIDTH-1:0]   m1_hi, m1_lo_unused, m1_x;

    logic                    m2_valid, m2_ready;
    logic [DATA_WIDTH-1:0]   m2_hi, m2_lo;
    logic [2*DATA_WIDTH-1:0] m2_side;

    logic [DATA_WIDTH-1:0]   quotient, remainder;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DATA_WIDTH'(DIVISOR_RESET);
            recip_reg   <= DATA_WIDTH'(RECIPROCAL_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DIVISOR:    divisor_reg <= cfg_wdata;
                CFG_RECIPROCAL: recip_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Estimate: high half of dividend * reciprocal
    idd_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .SIDE_W     (DATA_WIDTH)
    ) u_mul_est (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a      (s_tdata[DATA_WIDTH-1:0]),
        .in_b      (recip_reg),
        .in_side   (s_tdata[DATA_WIDTH-1:0]),
        .out_valid (m1_valid),
        .out_ready (m1_ready),
        .out_hi    (m1_hi),
        .out_lo    (m1_lo_unused),
        .out_side  (m1_x)
    );

    // Back-multiply: estimate * divisor, full width for the overflow test
    idd_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .SIDE_W     (2 * DATA_WIDTH)
    ) u_mul_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (m1_valid),
        .in_ready  (m1_ready),
        .in_a      (m1_hi),
        .in_b      (divisor_reg),
        .in_side   ({m1_hi, m1_x}),
        .out_valid (m2_valid),
        .out_ready (m2_ready),
        .out_hi    (m2_hi),
        .out_lo    (m2_lo),
        .out_side  (m2_side)
    );

    // Correction and output register
    idd_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .divisor       (divisor_reg),
        .in_valid      (m2_valid),
        .in_ready      (m2_ready),
        .in_prod_hi    (m2_hi),
        .in_prod_lo    (m2_lo),
        .in_est        (m2_side[2*DATA_WIDTH-1:DATA_WIDTH]),
        .in_dividend   (m2_side[DATA_WIDTH-1:0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_quotient  (quotient),
        .out_remainder (remainder)
    );

    assign m_tdata = OUT_TW'({remainder, quotient});

`ifndef NO_ASSERTIONS
    // Divisor one always yields a zero remainder
    a_bypass_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (divisor_reg == DATA_WIDTH'(DIVISOR_RESET)) |-> remainder == '0)
        else $error("bypass remainder not zero");

    // Zero divisor and zero reciprocal give a zero quotient
    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (divisor_reg == '0) && (recip_reg == '0) |-> quotient == '0)
        else $error("zero divisor quotient not zero");

    // An empty output stage lets the whole pipeline move
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

FILE: bench/invariant_divisor_divmod_core_tb.sv
`timescale 1ns / 1ps

module invariant_divisor_divmod_core_tb;
    import idd_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int SW = ((DW + 7) / 8) * 8;
    localparam int MW = ((2 * DW + 7) / 8) * 8;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};
    localparam int SETTLE_CYCLES = 12;      // pipeline is 8 deep
    localparam int DRAIN_LIMIT = 50000;

    // quotient in the low half, remainder above it
    typedef struct packed {
        logic [DW-1:0] remainder;
        logic [DW-1:0] quotient;
    } divmod_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_addr = CFG_DIVISOR;
    logic [DW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;      // dividend
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;           // quotient, remainder

    // register copies for prediction
    logic [DW-1:0] cur_divisor;
    logic [DW-1:0] cur_recip;

    divmod_t expected_divmods[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int divisor_loads = 0;

    invariant_divisor_divmod_core #(
        .DATA_WIDTH(DW)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

    // estimate from the reciprocal, at most one downward correction, wrapped remainder; divisor one bypasses
    function automatic divmod_t predict_divmod(input logic [DW-1:0] x);
        logic [2*DW-1:0] prod;
        logic [DW-1:0] q;
        divmod_t res;
        if (cur_divisor == 1) begin
            res.quotient = x;
            res.remainder = '0;
            return res;
        end
        prod = {{DW{1'b0}}, x} * {{DW{1'b0}}, cur_recip};
        q = prod[2*DW-1:DW];
        prod = {{DW{1'b0}}, q} * {{DW{1'b0}}, cur_divisor};
        if (prod[2*DW-1:DW] != '0 || prod[DW-1:0] > x)
            q = q - 1'b1;
        res.quotient = q;
        res.remainder = x - q * cur_divisor;
        return res;
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [DW-1:0] exact_recip(input logic [DW-1:0] d);
        return (d < 2) ? '0 : ALL_ONES / d + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] want,
                                   input logic [DW-1:0] got);
        $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
        error_count++;
    endtask

    // result side: check each accepted result, then pick next tready
    always @(posedge aclk) begin : result_check
        divmod_t want;
        divmod_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2*DW-1:0];
            if (expected_divmods.size() == 0) begin
                report_mismatch("result with no request pending", '0, got.quotient);
            end else begin
                want = expected_divmods.pop_front();
                if (got.quotient !== want.quotient)
                    report_mismatch("quotient", want.quotient, got.quotient);
                if (got.remainder !== want.remainder)
                    report_mismatch("remainder", want.remainder, got.remainder);
                results_checked++;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_dividend(input logic [DW-1:0] x);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_divmods.push_back(predict_divmod(x));
        requests_sent++;
    endtask

    // stop sending, let every pending result drain, then let the pipe settle
    task automatic wait_pipeline_empty();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_divmods.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic addr, input logic [DW-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (addr == CFG_DIVISOR)
            cur_divisor = value;
        else
            cur_recip = value;
    endtask

    task automatic load_divisor(input logic [DW-1:0] d, input logic [DW-1:0] r);
        wait_pipeline_empty();
        write_register(CFG_DIVISOR, d);
        write_register(CFG_RECIPROCAL, r);
        divisor_loads++;
    endtask

    // reset values give the bypass path
    task automatic test_bypass_after_reset();
        send_dividend('0);
        send_dividend(ALL_ONES);
        send_dividend({(DW/2){2'b10}});
        send_dividend({(DW/2){2'b01}});
    endtask

    task automatic test_directed_divisors();
        load_divisor(64'd2, exact_recip(64'd2));
        send_dividend('0);
        send_dividend(ALL_ONES);
        load_divisor(64'd3, exact_recip(64'd3));
        send_dividend(ALL_ONES);
        send_dividend(64'd299);
        send_dividend(64'd300);
        load_divisor(ALL_ONES, exact_recip(ALL_ONES));
        send_dividend(ALL_ONES);
        send_dividend(ALL_ONES - 1'b1);
        load_divisor(64'h8000_0000_0000_0000, exact_recip(64'h8000_0000_0000_0000));
        send_dividend(ALL_ONES);
        send_dividend(64'h7FFF_FFFF_FFFF_FFFF);
        // divisor zero with zero reciprocal passes the dividend to the remainder
        load_divisor('0, '0);
        send_dividend(ALL_ONES);
        send_dividend(64'd12345);
        // divisor one ignores any reciprocal
        load_divisor(64'd1, ALL_ONES);
        send_dividend(64'hDEAD_BEEF_0123_4567);
        // inconsistent reciprocals go through the raw datapath
        load_divisor(64'd10, ALL_ONES);
        send_dividend(ALL_ONES);
        send_dividend(64'd5);
        load_divisor(64'd7, '0);
        send_dividend(64'd100);
        load_divisor(64'd3, exact_recip(64'd3) + 64'd1000);
        send_dividend(rand_word());
        send_dividend(ALL_ONES);
        load_divisor(ALL_ONES, ALL_ONES);
        send_dividend(ALL_ONES);
    endtask

    function automatic logic [DW-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 64'd1;
            2, 3: return $urandom_range(2, 16);
            4: return 64'd1 << $urandom_range(1, DW - 1);
            5: return {32'd0, $urandom} | 64'd2;
            6: return ALL_ONES - $urandom_range(0, 3);
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_recip(input logic [DW-1:0] d);
        case ($urandom_range(0, 19))
            0: return rand_word();
            1: return exact_recip(d) + $urandom_range(1, 4);
            2: return exact_recip(d) - $urandom_range(1, 4);
            default: return exact_recip(d);
        endcase
    endfunction

    // dividends: small, near all ones, near a multiple of the divisor (for the correction step) or random
    function automatic logic [DW-1:0] pick_dividend();
        logic [DW-1:0] k;
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 255);
            1: return ALL_ONES - $urandom_range(0, 255);
            2: begin
                if (cur_divisor < 2)
                    return rand_word();
                k = rand_word() % (ALL_ONES / cur_divisor + 1'b1);
                return k * cur_divisor + $urandom_range(0, 2) - 1;
            end
            default: return rand_word();
        endcase
    endfunction

    task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
        logic [DW-1:0] d;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                d = pick_divisor();
                load_divisor(d, pick_recip(d));
            end
            send_dividend(pick_dividend());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        cur_divisor = DIVISOR_RESET;
        cur_recip = RECIPROCAL_RESET;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        test_bypass_after_reset();
        test_directed_divisors();
        test_random_stream(380, 28, 88);
        test_random_stream(380, 88, 28);
        test_random_stream(380, 0, 0);
        wait_pipeline_empty();

        if (expected_divmods.size() != 0)
            report_mismatch("results never returned", expected_divmods.size(), '0);
        $display("Sent %0d dividends over %0d divisor settings, checked %0d results.",
                 requests_sent, divisor_loads, results_checked);
        $display("Mismatches: %0d", error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
